### rtl/scm_pkg.sv
// shared types and constants for the stepper calibrate-and-move core
// no dependencies
package scm_pkg;

  localparam int POS_BITS_DEF    = 16;
  localparam int DELAY_SCALE_DEF = 10;

  localparam int ELAPSED_W = 20;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
  localparam logic [14:0] TRAVEL_MAX = 15'h7fff;

  localparam logic [15:0] SLOW_DELAY_RST = 16'd1000;
  localparam logic [15:0] RUN_DELAY_RST  = 16'd500;

  // item kinds
  localparam logic [2:0] KIND_TICK      = 3'd0;
  localparam logic [2:0] KIND_SLOW_MOVE = 3'd1;
  localparam logic [2:0] KIND_SET_ZERO  = 3'd2;
  localparam logic [2:0] KIND_MOVE_END  = 3'd3;
  localparam logic [2:0] KIND_SET_END   = 3'd4;
  localparam logic [2:0] KIND_TEST_RUN  = 3'd5;
  localparam logic [2:0] KIND_STOP      = 3'd6;

  // modes
  localparam logic [2:0] MODE_IDLE     = 3'd0;
  localparam logic [2:0] MODE_SLOW     = 3'd1;
  localparam logic [2:0] MODE_ZERO_SET = 3'd2;
  localparam logic [2:0] MODE_TO_END   = 3'd3;
  localparam logic [2:0] MODE_END_SET  = 3'd4;
  localparam logic [2:0] MODE_TEST_RUN = 3'd5;

  // travel direction
  localparam logic [1:0] DIR_ZERO = 2'd0;
  localparam logic [1:0] DIR_END  = 2'd1;
  localparam logic [1:0] DIR_NONE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_SLOW_DELAY = 2'd0;
  localparam logic [1:0] CFG_RUN_DELAY  = 2'd1;
  localparam logic [1:0] CFG_REVERSE    = 2'd2;

  // coil patterns A+,A-,B+,B-
  localparam logic [3:0] COIL_OFF = 4'd0;
  localparam logic [3:0] COIL_P0  = 4'd9;
  localparam logic [3:0] COIL_P1  = 4'd5;
  localparam logic [3:0] COIL_P2  = 4'd6;
  localparam logic [3:0] COIL_P3  = 4'd10;

  typedef struct packed {
    logic [2:0] kind;
    logic       direction;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         coil_drive;
    logic               report_valid;
    logic               reported_side;
    logic               end_ack_valid;
    logic [14:0]        travel_length;
    logic               rejected;
    logic               moving;
    logic [2:0]         mode;
    logic signed [15:0] step_position;
  } out_item_t;

  function automatic logic [3:0] coil_pattern(input logic [1:0] idx);
    logic [3:0] p;
    case (idx)
      2'd0: p = COIL_P0;
      2'd1: p = COIL_P1;
      2'd2: p = COIL_P2;
      default: p = COIL_P3;
    endcase
    return p;
  endfunction

endpackage

### rtl/stepper_calibrate_and_move_core.sv
// stepper calibrate-and-move core: full-step sequencer with end-point calibration
// an accepted item passes the input register, then the result register
// throughput: one item per cycle unless stalled; update is one combinational pass
// reset: sync active-low rst_n clears state, not data regs; delays to 1000, 500
// depends on scm_pkg
module stepper_calibrate_and_move_core #(
  parameter int POS_BITS    = scm_pkg::POS_BITS_DEF,
  parameter int DELAY_SCALE = scm_pkg::DELAY_SCALE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  scm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output scm_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  localparam int PW  = POS_BITS;
  localparam int EW  = ((PW > 16) ? PW : 16) + 2;
  localparam int MW  = 16 + $clog2(DELAY_SCALE + 1);
  localparam int PRW = (MW > scm_pkg::ELAPSED_W) ? MW : scm_pkg::ELAPSED_W + 1;
  localparam logic signed [PW-1:0] PMAX = {1'b0, {(PW-1){1'b1}}};
  localparam logic signed [PW-1:0] PMIN = {1'b1, {(PW-1){1'b0}}};

  // config
  logic [15:0] slow_delay_r, run_delay_r;
  logic        reverse_r;

  // pipeline
  logic              s1_valid_r;
  scm_pkg::in_item_t s1_data_r;
  logic              out_valid_r;
  scm_pkg::out_item_t out_data_r, out_data_nxt;
  logic              advance;

  // block state
  logic [2:0]                    mode_r, mode_nxt;
  logic                          moving_r, moving_nxt;
  logic signed [PW-1:0]          pos_r, pos_nxt;
  logic signed [PW-1:0]          target_r, target_nxt;
  logic [14:0]                   travel_r, travel_nxt;
  logic [1:0]                    dir_r, dir_nxt;
  logic [1:0]                    pat_r, pat_nxt;
  logic [3:0]                    coil_r, coil_nxt;
  logic [15:0]                   delay_r, delay_nxt;
  logic [scm_pkg::ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic                          side_r, side_nxt;

  // helpers
  logic signed [EW-1:0]          posx, tlx, magx, pmx, posx_nxt;
  logic signed [PW-1:0]          pos_up, pos_dn, pos_move, travel_clamped;
  logic [14:0]                   mag_sat;
  logic [PRW-1:0]                prod;
  logic [scm_pkg::ELAPSED_W-1:0] thr, elapsed_inc;
  logic [1:0]                    pat_step;
  logic                          rep_valid, rep_side, ack, rej;
  logic [3:0]                    coil_out;

  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign posx = {{(EW-PW){pos_r[PW-1]}}, pos_r};
  assign tlx  = {{(EW-15){1'b0}}, travel_r};
  assign pmx  = {{(EW-PW){1'b0}}, PMAX};
  assign magx = posx[EW-1] ? -posx : posx;
  assign mag_sat = (magx > EW'(signed'({1'b0, scm_pkg::TRAVEL_MAX}))) ? scm_pkg::TRAVEL_MAX
                                                                      : magx[14:0];
  assign travel_clamped = (tlx > pmx) ? PMAX : tlx[PW-1:0];

  assign pos_up   = (pos_r == PMAX) ? pos_r : pos_r + PW'(1);
  assign pos_dn   = (pos_r == PMIN) ? pos_r : pos_r - PW'(1);
  assign pos_move = (dir_r == scm_pkg::DIR_ZERO) ? pos_dn : pos_up;
  assign pat_step = (dir_r == scm_pkg::DIR_ZERO) ? pat_r + 2'd1 : pat_r - 2'd1;

  assign prod = PRW'(delay_r) * PRW'(DELAY_SCALE);
  assign thr  = (prod > PRW'(scm_pkg::ELAPSED_MAX)) ? scm_pkg::ELAPSED_MAX
                                                    : prod[scm_pkg::ELAPSED_W-1:0];
  assign elapsed_inc = (elapsed_r == scm_pkg::ELAPSED_MAX) ? elapsed_r
                                                           : elapsed_r + 1'b1;

  always_comb begin
    mode_nxt    = mode_r;
    moving_nxt  = moving_r;
    pos_nxt     = pos_r;
    target_nxt  = target_r;
    travel_nxt  = travel_r;
    dir_nxt     = dir_r;
    pat_nxt     = pat_r;
    coil_nxt    = coil_r;
    delay_nxt   = delay_r;
    elapsed_nxt = elapsed_r;
    side_nxt    = side_r;
    rep_valid   = 1'b0;
    rep_side    = 1'b0;
    ack         = 1'b0;
    rej         = 1'b0;
    case (s1_data_r.kind)
      scm_pkg::KIND_TICK: begin
        elapsed_nxt = elapsed_inc;
        if (moving_r && (elapsed_inc >= thr)) begin
          elapsed_nxt = '0;
          if (mode_r == scm_pkg::MODE_SLOW || mode_r == scm_pkg::MODE_TO_END) begin
            coil_nxt = scm_pkg::coil_pattern(pat_r);
            pat_nxt  = pat_step;
            pos_nxt  = pos_move;
          end else if (mode_r == scm_pkg::MODE_TEST_RUN) begin
            if (pos_r == target_r || pos_r[PW-1]) begin
              moving_nxt = 1'b0;
              side_nxt   = (posx == tlx);
              rep_valid  = 1'b1;
              rep_side   = (posx == tlx);
              mode_nxt   = scm_pkg::MODE_IDLE;
            end else begin
              coil_nxt = scm_pkg::coil_pattern(pat_r);
              pat_nxt  = pat_step;
              pos_nxt  = pos_move;
            end
          end
        end
      end
      scm_pkg::KIND_SLOW_MOVE, scm_pkg::KIND_MOVE_END: begin
        dir_nxt    = {1'b0, s1_data_r.direction};
        delay_nxt  = slow_delay_r;
        moving_nxt = 1'b1;
        mode_nxt   = s1_data_r.kind;
      end
      scm_pkg::KIND_SET_ZERO: begin
        moving_nxt = 1'b0;
        pos_nxt    = '0;
        side_nxt   = 1'b0;
        rep_valid  = 1'b1;
        mode_nxt   = scm_pkg::MODE_ZERO_SET;
      end
      scm_pkg::KIND_SET_END: begin
        moving_nxt = 1'b0;
        travel_nxt = mag_sat;
        ack        = 1'b1;
        side_nxt   = 1'b1;
        rep_valid  = 1'b1;
        rep_side   = 1'b1;
        delay_nxt  = run_delay_r;
        mode_nxt   = scm_pkg::MODE_END_SET;
      end
      scm_pkg::KIND_TEST_RUN: begin
        delay_nxt = run_delay_r;
        if (side_r == s1_data_r.direction) begin
          rej = 1'b1;
        end else begin
          if (s1_data_r.direction) begin
            dir_nxt    = scm_pkg::DIR_END;
            pos_nxt    = '0;
            target_nxt = travel_clamped;
          end else begin
            dir_nxt    = scm_pkg::DIR_ZERO;
            pos_nxt    = travel_clamped;
            target_nxt = '0;
          end
          mode_nxt   = scm_pkg::MODE_TEST_RUN;
          moving_nxt = 1'b1;
        end
      end
      scm_pkg::KIND_STOP: begin
        moving_nxt = 1'b0;
        coil_nxt   = scm_pkg::COIL_OFF;
      end
      default: begin
      end
    endcase
  end

  assign posx_nxt = {{(EW-PW){pos_nxt[PW-1]}}, pos_nxt};

  always_comb begin
    coil_out = reverse_r ? {coil_nxt[0], coil_nxt[1], coil_nxt[2], coil_nxt[3]} : coil_nxt;
    out_data_nxt.coil_drive    = coil_out;
    out_data_nxt.report_valid  = rep_valid;
    out_data_nxt.reported_side = rep_side;
    out_data_nxt.end_ack_valid = ack;
    out_data_nxt.travel_length = travel_nxt;
    out_data_nxt.rejected      = rej;
    out_data_nxt.moving        = moving_nxt;
    out_data_nxt.mode          = mode_nxt;
    out_data_nxt.step_position = posx_nxt[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slow_delay_r <= scm_pkg::SLOW_DELAY_RST;
      run_delay_r  <= scm_pkg::RUN_DELAY_RST;
      reverse_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        scm_pkg::CFG_SLOW_DELAY: slow_delay_r <= cfg_wdata;
        scm_pkg::CFG_RUN_DELAY:  run_delay_r  <= cfg_wdata;
        scm_pkg::CFG_REVERSE:    reverse_r    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= scm_pkg::MODE_IDLE;
      moving_r  <= 1'b0;
      pos_r     <= '0;
      target_r  <= '0;
      travel_r  <= '0;
      dir_r     <= scm_pkg::DIR_NONE;
      pat_r     <= '0;
      coil_r    <= scm_pkg::COIL_OFF;
      delay_r   <= '0;
      elapsed_r <= '0;
      side_r    <= 1'b0;
    end else if (advance) begin
      mode_r    <= mode_nxt;
      moving_r  <= moving_nxt;
      pos_r     <= pos_nxt;
      target_r  <= target_nxt;
      travel_r  <= travel_nxt;
      dir_r     <= dir_nxt;
      pat_r     <= pat_nxt;
      coil_r    <= coil_nxt;
      delay_r   <= delay_nxt;
      elapsed_r <= elapsed_nxt;
      side_r    <= side_nxt;
    end
  end

endmodule

### rtl/scm_checker.sv
// port-level checks for the stepper calibrate-and-move core
// depends on scm_pkg; bound to stepper_calibrate_and_move_core
module scm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input scm_pkg::out_item_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // side is only reported with a report
  a_side_qual: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.reported_side |-> out_data.report_valid)
    else $error("reported side without report");

  // end ack comes with an end-point report, stopped, in end-set mode
  a_end_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.end_ack_valid |->
      out_data.report_valid && out_data.reported_side && !out_data.moving &&
      out_data.mode == scm_pkg::MODE_END_SET)
    else $error("bad end ack");

  // a refused test run issues no report
  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.rejected |-> !out_data.report_valid && !out_data.end_ack_valid)
    else $error("rejected item carries a report");

  // coils show off or a legal full-step pattern
  a_coil: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.coil_drive == scm_pkg::COIL_OFF ||
      out_data.coil_drive == scm_pkg::COIL_P0 || out_data.coil_drive == scm_pkg::COIL_P1 ||
      out_data.coil_drive == scm_pkg::COIL_P2 || out_data.coil_drive == scm_pkg::COIL_P3)
    else $error("illegal coil pattern");

endmodule

bind stepper_calibrate_and_move_core scm_checker u_scm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
